// ----- design/mec_pkg.sv -----
// Shared widths, register indexes and control structs for the escape-time counter.
package mec_pkg;

  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 12;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 24;
  localparam int CFG_IDX_W = 3;

  // iterate width: |x|, |y| < 2.0 between iterations
  localparam int ZW = FRAC_BITS + 2;
  // exact product width
  localparam int PW = 2 * ZW;
  // mapped point: origin + index * step
  localparam int MW = COORD_W + 1 + DATA_W;
  localparam int CW = MW + 1;
  // updated iterate before the bound test
  localparam int XW = ((CW > FRAC_BITS + 3) ? CW : FRAC_BITS + 3) + 2;
  // sum of squares, escape at 4.0
  localparam int SW = 2 * FRAC_BITS + 3;

  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd4;

  localparam logic signed [DATA_W-1:0] ORIGIN_RST = -32'sd536870912;
  localparam logic signed [DATA_W-1:0] STEP_RST   = 32'sd262144;
  localparam logic [COUNT_W-1:0]       LIMIT_RST  = 24'd256;

  typedef struct packed {
    logic load_in;
    logic map;
    logic square;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sq_escape;
    logic at_limit;
    logic bound_escape;
  } sts_t;

endpackage

// ----- design/mec_ctrl.sv -----
// Sequencer for the escape-time counter: mapping, square and update steps, result hand-off.
module mec_ctrl
  import mec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SQUARE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.sq_escape || sts_i.at_limit) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = sts_i.bound_escape ? ST_DONE : ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/mec_datapath.sv -----
// Datapath: config registers, point mapping, square and update arithmetic, result register.
module mec_datapath
  import mec_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic [COORD_W-1:0]   column_i,
  input  logic [COORD_W-1:0]   row_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [COORD_W-1:0]   out_column_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COUNT_W-1:0]   escape_count_o
);

  localparam logic signed [XW-1:0] TWO_X = XW'(1) << (FRAC_BITS + 1);

  logic signed [DATA_W-1:0] real_origin_q, imag_origin_q, real_step_q, imag_step_q;
  logic [COUNT_W-1:0]       limit_q;

  logic [COORD_W-1:0]       col_q, row_q;
  logic signed [CW-1:0]     c_re_q, c_im_q;
  logic signed [ZW-1:0]     x_q, y_q;
  logic signed [PW-1:0]     xx_q, yy_q, xy_q;
  logic [COUNT_W-1:0]       count_q;
  logic [COORD_W-1:0]       out_col_q, out_row_q;
  logic [COUNT_W-1:0]       out_count_q;

  logic [COORD_W-1:0]       ci, ri;
  logic signed [MW-1:0]     prod_re, prod_im;
  logic signed [XW-1:0]     x_new, y_new;
  logic [SW-1:0]            sq_sum;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= ORIGIN_RST;
      imag_origin_q <= ORIGIN_RST;
      real_step_q   <= STEP_RST;
      imag_step_q   <= STEP_RST;
      limit_q       <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REAL_ORIGIN:     real_origin_q <= cfg_data_i;
        REG_IMAG_ORIGIN:     imag_origin_q <= cfg_data_i;
        REG_REAL_STEP:       real_step_q   <= cfg_data_i;
        REG_IMAG_STEP:       imag_step_q   <= cfg_data_i;
        REG_ITERATION_LIMIT: limit_q       <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp indexes to the last pixel
  always_comb begin
    ci = (32'(col_q) >= 32'(MAX_DIM)) ? COORD_W'(MAX_DIM - 1) : col_q;
    ri = (32'(row_q) >= 32'(MAX_DIM)) ? COORD_W'(MAX_DIM - 1) : row_q;
    prod_re = $signed({1'b0, ci}) * real_step_q;
    prod_im = $signed({1'b0, ri}) * imag_step_q;
  end

  always_comb begin
    x_new  = XW'(xx_q >>> FRAC_BITS) - XW'(yy_q >>> FRAC_BITS) + XW'(c_re_q);
    y_new  = XW'(xy_q >>> (FRAC_BITS - 1)) + XW'(c_im_q);
    sq_sum = {1'b0, xx_q[SW-2:0]} + {1'b0, yy_q[SW-2:0]};
  end

  assign sts_o.sq_escape    = sq_sum[SW-1];
  assign sts_o.at_limit     = (count_q >= limit_q);
  assign sts_o.bound_escape = (x_new >= TWO_X) || (x_new <= -TWO_X) ||
                              (y_new >= TWO_X) || (y_new <= -TWO_X);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (cmd_i.map) begin
      c_re_q  <= CW'(real_origin_q) + CW'(prod_re);
      c_im_q  <= CW'(imag_origin_q) + CW'(prod_im);
      x_q     <= '0;
      y_q     <= '0;
      count_q <= '0;
    end
    if (cmd_i.square) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
    if (cmd_i.update) begin
      x_q     <= x_new[ZW-1:0];
      y_q     <= y_new[ZW-1:0];
      count_q <= count_q + COUNT_W'(1);
    end
    if (cmd_i.load_out) begin
      out_col_q   <= col_q;
      out_row_q   <= row_q;
      out_count_q <= count_q;
    end
  end

  assign out_column_o   = out_col_q;
  assign out_row_o      = out_row_q;
  assign escape_count_o = out_count_q;

endmodule

// ----- design/mandelbrot_escape_count.sv -----
// Top level of the escape-time counter: sequencer, datapath and checks.
//
// Input channel (in_valid_i/in_ready_o) takes one pixel (column_i, row_i);
// output channel (out_valid_o/out_ready_i) returns the coordinate as
// received with escape_count_o. Config registers are written through
// cfg_we_i/cfg_index_i/cfg_data_i; the user must do so only while no pixel
// is in flight, and the block leaves this unchecked. One pixel is worked on
// at a time. After a transfer in, the map step maps the pixel to c, then
// each iteration runs a square step for the three exact products and an
// update step for the update and the escape tests. A pixel finishes when
// |x| or |y| reaches 2.0 after an update, or when |z|^2 reaches 4.0 or the
// count reaches the iteration limit, the update then being skipped. The
// next pixel can be taken in the cycle in which the finished result turns valid.
// The result sits in an output register, so the next pixel is taken while
// a result waits; a finished pixel holds until that register frees up.
// Reset clears the sequencer and the output valid, and loads the config
// defaults: origins -2.0, steps 1/1024, iteration limit 256.
module mandelbrot_escape_count
  import mec_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COORD_W-1:0]   column_i,
  input  logic [COORD_W-1:0]   row_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COORD_W-1:0]   out_column_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COUNT_W-1:0]   escape_count_o
);

  cmd_t cmd;
  sts_t sts;

  mec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mec_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .escape_count_o (escape_count_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.map, cmd.square, cmd.update, cmd.load_out}))
    else $error("more than one datapath command");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a pixel is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before transfer");

  a_map_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |=> cmd.map)
    else $error("mapping step missed after transfer in");

endmodule
